// ===== hdl/binary_min_heap_macros.svh =====
// Assertion macros shared by the binary min-heap RTL.
`ifndef BINARY_MIN_HEAP_MACROS_SVH
`define BINARY_MIN_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define BMH_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BMH_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BMH_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define BMH_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/bmh_pkg.sv =====
// Types and constants of the binary min-heap priority queue.
package bmh_pkg;

  localparam int WEIGHT_W    = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 9;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_POP_LOAD,
    ST_DN_L,
    ST_DN_R,
    ST_DN_SEL,
    ST_DN_MOV,
    ST_DONE
  } bmh_state_t;

endpackage

// ===== hdl/bmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/binary_min_heap.sv =====
// Top level of the binary min-heap priority queue with a sequenced sift engine.
//
//   Channel | Ports                                         | Handshake
//   --------+-----------------------------------------------+---------------------------
//   request | in_command, in_key_weight, in_tag             | start high while busy low
//   result  | out_status, out_weight, out_tag,              | out_valid for one cycle
//           | out_entry_count, out_is_empty                 |
//
// Every heap read goes through the single read port of the heap RAM, one read per cycle.
// An insert climbs through a parent read (ST_UP_RD) and a compare-and-write (ST_UP_CMP) per level;
// a pop reads the root, then the last entry, loads it, and sinks through a left-child read, a
// right-child read, a select if there is a right child and a move (ST_DN_L to ST_DN_MOV) per level.
// Refused requests go straight to ST_DONE; reset clears only the entry count and the sequencer.
// The result strobe cannot be stalled; busy falls the cycle after out_valid.
`include "binary_min_heap_macros.svh"

module binary_min_heap #(
  parameter int HEAP_DEPTH = 512,
  parameter int TAG_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic [bmh_pkg::WEIGHT_W-1:0]        in_key_weight,
  input  logic [TAG_BITS-1:0]                 in_tag,
  output logic                                out_valid,
  output logic [bmh_pkg::STATUS_W-1:0]        out_status,
  output logic [bmh_pkg::WEIGHT_W-1:0]        out_weight,
  output logic [TAG_BITS-1:0]                 out_tag,
  output logic [bmh_pkg::COUNT_OUT_W-1:0]     out_entry_count,
  output logic                                out_is_empty
);

  localparam int CW = $clog2(HEAP_DEPTH);
  localparam int EW = bmh_pkg::WEIGHT_W + TAG_BITS;
  localparam logic [CW-1:0] MAX_COUNT = CW'(HEAP_DEPTH - 1);
  localparam logic [CW-1:0] ROOT_SLOT = CW'(1);

  bmh_pkg::bmh_state_t state_r, state_nxt;

  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   hole_r, hole_nxt;
  logic [bmh_pkg::WEIGHT_W-1:0]    mw_r, mw_nxt;
  logic [TAG_BITS-1:0]             mt_r, mt_nxt;
  logic [bmh_pkg::WEIGHT_W-1:0]    ch_w_r, ch_w_nxt;
  logic [TAG_BITS-1:0]             ch_t_r, ch_t_nxt;
  logic [CW-1:0]                   ch_idx_r, ch_idx_nxt;
  logic [bmh_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [bmh_pkg::WEIGHT_W-1:0]    ow_r, ow_nxt;
  logic [TAG_BITS-1:0]             ot_r, ot_nxt;

  logic                            mem_we;
  logic [CW-1:0]                   mem_waddr;
  logic [EW-1:0]                   mem_wdata;
  logic [CW-1:0]                   mem_raddr;
  logic [EW-1:0]                   mem_rdata;
  logic [bmh_pkg::WEIGHT_W-1:0]    rd_w;
  logic [TAG_BITS-1:0]             rd_t;

  logic [bmh_pkg::WEIGHT_W-1:0]    cmp_a, cmp_b;
  logic                            cmp_lt;

  logic [CW:0]                     left_slot;
  logic                            has_left;
  logic                            accept;
  logic [CW+bmh_pkg::COUNT_OUT_W-1:0] count_ext;

  bmh_ram #(
    .WIDTH (EW),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_w = mem_rdata[EW-1:TAG_BITS];
  assign rd_t = mem_rdata[TAG_BITS-1:0];

  assign left_slot = {hole_r, 1'b0};
  assign has_left  = (left_slot <= {1'b0, count_r});
  assign busy      = (state_r != bmh_pkg::ST_IDLE);
  assign accept    = start && !busy;

  // The one weight comparator, shared by the compare steps of both sifts.
  always_comb begin
    unique case (state_r)
      bmh_pkg::ST_UP_CMP: begin
        cmp_a = mw_r;
        cmp_b = rd_w;
      end
      bmh_pkg::ST_DN_SEL: begin
        cmp_a = rd_w;
        cmp_b = ch_w_r;
      end
      default: begin
        cmp_a = ch_w_r;
        cmp_b = mw_r;
      end
    endcase
  end

  assign cmp_lt = (cmp_a < cmp_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmh_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hole_r   <= hole_nxt;
    mw_r     <= mw_nxt;
    mt_r     <= mt_nxt;
    ch_w_r   <= ch_w_nxt;
    ch_t_r   <= ch_t_nxt;
    ch_idx_r <= ch_idx_nxt;
    status_r <= status_nxt;
    ow_r     <= ow_nxt;
    ot_r     <= ot_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    hole_nxt   = hole_r;
    mw_nxt     = mw_r;
    mt_nxt     = mt_r;
    ch_w_nxt   = ch_w_r;
    ch_t_nxt   = ch_t_r;
    ch_idx_nxt = ch_idx_r;
    status_nxt = status_r;
    ow_nxt     = ow_r;
    ot_nxt     = ot_r;
    mem_we     = 1'b0;
    mem_waddr  = hole_r;
    mem_wdata  = {mw_r, mt_r};
    mem_raddr  = ROOT_SLOT;
    out_valid  = 1'b0;

    unique case (state_r)
      bmh_pkg::ST_IDLE: begin
        if (accept) begin
          status_nxt = bmh_pkg::STATUS_OK;
          ow_nxt     = '0;
          ot_nxt     = '0;
          mw_nxt     = in_key_weight;
          mt_nxt     = in_tag;
          if (in_command == bmh_pkg::CMD_INSERT) begin
            if (count_r == MAX_COUNT) begin
              status_nxt = bmh_pkg::STATUS_FULL;
              state_nxt  = bmh_pkg::ST_DONE;
            end else begin
              count_nxt = count_r + 1'b1;
              hole_nxt  = count_r + 1'b1;
              state_nxt = bmh_pkg::ST_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = bmh_pkg::STATUS_EMPTY;
              state_nxt  = bmh_pkg::ST_DONE;
            end else begin
              state_nxt = bmh_pkg::ST_POP_ROOT;
            end
          end
        end
      end
      bmh_pkg::ST_UP_RD: begin
        if (hole_r > ROOT_SLOT) begin
          mem_raddr = hole_r >> 1;
          state_nxt = bmh_pkg::ST_UP_CMP;
        end else begin
          mem_we    = 1'b1;
          state_nxt = bmh_pkg::ST_DONE;
        end
      end
      bmh_pkg::ST_UP_CMP: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = mem_rdata;
          hole_nxt  = hole_r >> 1;
          state_nxt = bmh_pkg::ST_UP_RD;
        end else begin
          state_nxt = bmh_pkg::ST_DONE;
        end
      end
      bmh_pkg::ST_POP_ROOT: begin
        mem_raddr = ROOT_SLOT;
        state_nxt = bmh_pkg::ST_POP_LAST;
      end
      bmh_pkg::ST_POP_LAST: begin
        ow_nxt    = rd_w;
        ot_nxt    = rd_t;
        mem_raddr = count_r;
        state_nxt = bmh_pkg::ST_POP_LOAD;
      end
      bmh_pkg::ST_POP_LOAD: begin
        mw_nxt    = rd_w;
        mt_nxt    = rd_t;
        count_nxt = count_r - 1'b1;
        hole_nxt  = ROOT_SLOT;
        state_nxt = bmh_pkg::ST_DN_L;
      end
      bmh_pkg::ST_DN_L: begin
        if (has_left) begin
          mem_raddr = left_slot[CW-1:0];
          state_nxt = bmh_pkg::ST_DN_R;
        end else begin
          mem_we    = 1'b1;
          state_nxt = bmh_pkg::ST_DONE;
        end
      end
      bmh_pkg::ST_DN_R: begin
        ch_w_nxt   = rd_w;
        ch_t_nxt   = rd_t;
        ch_idx_nxt = left_slot[CW-1:0];
        mem_raddr  = {hole_r[CW-2:0], 1'b1};
        if (left_slot[CW-1:0] == count_r) begin
          state_nxt = bmh_pkg::ST_DN_MOV;
        end else begin
          state_nxt = bmh_pkg::ST_DN_SEL;
        end
      end
      bmh_pkg::ST_DN_SEL: begin
        if (cmp_lt) begin
          ch_w_nxt   = rd_w;
          ch_t_nxt   = rd_t;
          ch_idx_nxt = {hole_r[CW-2:0], 1'b1};
        end
        state_nxt = bmh_pkg::ST_DN_MOV;
      end
      bmh_pkg::ST_DN_MOV: begin
        mem_we = 1'b1;
        if (cmp_lt) begin
          mem_wdata = {ch_w_r, ch_t_r};
          hole_nxt  = ch_idx_r;
          state_nxt = bmh_pkg::ST_DN_L;
        end else begin
          state_nxt = bmh_pkg::ST_DONE;
        end
      end
      bmh_pkg::ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = bmh_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bmh_pkg::ST_IDLE;
      end
    endcase
  end

  assign count_ext       = {{bmh_pkg::COUNT_OUT_W{1'b0}}, count_r};
  assign out_status      = status_r;
  assign out_weight      = ow_r;
  assign out_tag         = ot_r;
  assign out_entry_count = count_ext[bmh_pkg::COUNT_OUT_W-1:0];
  assign out_is_empty    = (count_r == '0);

  `BMH_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy, "Accepted request did not raise busy.")
  `BMH_ASSERT_NXT(a_result_idle, clk, rst_n, out_valid, !busy, "Busy stayed high after a result.")
  `BMH_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= MAX_COUNT, "Entry count beyond capacity.")
  `BMH_ASSERT_IMP(a_write_busy, clk, rst_n, mem_we, busy, "Heap RAM written while idle.")
  `BMH_ASSERT_IMP(a_refused_hold, clk, rst_n, out_valid && (out_status != bmh_pkg::STATUS_OK), ($past(count_r) == count_r) && (out_weight == '0), "Refused request changed state.")

endmodule

// ===== sim/binary_min_heap_checker.sv =====
// Checker for the binary min-heap: predicts each result from the accepted requests and compares.
module binary_min_heap_checker
  import bmh_pkg::*;
#(
  parameter int HEAP_DEPTH = 512,
  parameter int TAG_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   in_command,
  input  logic [WEIGHT_W-1:0]    in_key_weight,
  input  logic [TAG_BITS-1:0]    in_tag,
  input  logic                   out_valid,
  input  logic [STATUS_W-1:0]    out_status,
  input  logic [WEIGHT_W-1:0]    out_weight,
  input  logic [TAG_BITS-1:0]    out_tag,
  input  logic [COUNT_OUT_W-1:0] out_entry_count,
  input  logic                   out_is_empty,
  output int                     mismatch_count,
  output int                     results_pending,
  output int                     full_seen,
  output int                     empty_seen
);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [WEIGHT_W-1:0]    weight;
    logic [TAG_BITS-1:0]    tag;
    logic [COUNT_OUT_W-1:0] count;
    logic                   empty;
  } heap_result_t;

  logic [WEIGHT_W-1:0] slot_weight [HEAP_DEPTH];
  logic [TAG_BITS-1:0] slot_tag [HEAP_DEPTH];
  int                  held_count;
  heap_result_t        expected_q [$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    full_seen       = 0;
    empty_seen      = 0;
    held_count      = 0;
  end

  function automatic heap_result_t apply_request(input logic cmd,
                                                 input logic [WEIGHT_W-1:0] w,
                                                 input logic [TAG_BITS-1:0] t);
    heap_result_t        r;
    int                  hole;
    int                  child;
    logic                sinking;
    logic [WEIGHT_W-1:0] mw;
    logic [TAG_BITS-1:0] mt;
    r = '0;
    if (cmd == CMD_INSERT) begin
      if (held_count >= HEAP_DEPTH - 1) begin
        r.status = STATUS_FULL;
      end else begin
        held_count++;
        hole = held_count;
        while (hole > 1 && w < slot_weight[hole / 2]) begin
          slot_weight[hole] = slot_weight[hole / 2];
          slot_tag[hole]    = slot_tag[hole / 2];
          hole              = hole / 2;
        end
        slot_weight[hole] = w;
        slot_tag[hole]    = t;
      end
    end else if (held_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.status = STATUS_OK;
      r.weight = slot_weight[1];
      r.tag    = slot_tag[1];
      mw       = slot_weight[held_count];
      mt       = slot_tag[held_count];
      held_count--;
      hole    = 1;
      sinking = 1'b1;
      while (sinking && hole * 2 <= held_count) begin
        child = hole * 2;
        if (child != held_count && slot_weight[child + 1] < slot_weight[child]) child++;
        if (slot_weight[child] < mw) begin
          slot_weight[hole] = slot_weight[child];
          slot_tag[hole]    = slot_tag[child];
          hole              = child;
        end else begin
          sinking = 1'b0;
        end
      end
      slot_weight[hole] = mw;
      slot_tag[hole]    = mt;
    end
    r.count = held_count[COUNT_OUT_W-1:0];
    r.empty = (held_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (!rst_n) begin
      held_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_status != want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatch_count++;
          end
          if (out_weight != want.weight) begin
            $error("out_weight: expected %0h, got %0h", want.weight, out_weight);
            mismatch_count++;
          end
          if (out_tag != want.tag) begin
            $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
            mismatch_count++;
          end
          if (out_entry_count != want.count) begin
            $error("out_entry_count: expected %0d, got %0d", want.count, out_entry_count);
            mismatch_count++;
          end
          if (out_is_empty != want.empty) begin
            $error("out_is_empty: expected %0d, got %0d", want.empty, out_is_empty);
            mismatch_count++;
          end
          if (want.status == STATUS_FULL) full_seen++;
          if (want.status == STATUS_EMPTY) empty_seen++;
        end
      end
      if (start && !busy) begin
        expected_q.push_back(apply_request(in_command, in_key_weight, in_tag));
      end
    end
    results_pending = expected_q.size();
  end

endmodule

// ===== sim/binary_min_heap_tb.sv =====
// Testbench top for the binary min-heap: drives requests and reports the verdict.
module binary_min_heap_tb;
  import bmh_pkg::*;

  localparam int HEAP_DEPTH  = 512;
  localparam int TAG_BITS    = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_command;
  logic [WEIGHT_W-1:0]    in_key_weight;
  logic [TAG_BITS-1:0]    in_tag;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [WEIGHT_W-1:0]    out_weight;
  logic [TAG_BITS-1:0]    out_tag;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  logic                   out_is_empty;

  int mismatch_count;
  int results_pending;
  int full_seen;
  int empty_seen;

  int cycle_count = 0;
  int burst_left  = 0;
  int fill_level  = 0;
  int insert_sent = 0;
  int pop_sent    = 0;

  binary_min_heap #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key_weight  (in_key_weight),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_weight     (out_weight),
    .out_tag        (out_tag),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty)
  );

  binary_min_heap_checker #(
    .HEAP_DEPTH(HEAP_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) heap_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_key_weight  (in_key_weight),
    .in_tag         (in_tag),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_weight     (out_weight),
    .out_tag        (out_tag),
    .out_entry_count(out_entry_count),
    .out_is_empty   (out_is_empty),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending),
    .full_seen      (full_seen),
    .empty_seen     (empty_seen)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return WEIGHT_W'($urandom_range(0, 15));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  function automatic logic [TAG_BITS-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return TAG_BITS'($urandom);
    endcase
  endfunction

  task automatic issue_request(input logic cmd, input logic [WEIGHT_W-1:0] w,
                               input logic [TAG_BITS-1:0] t);
    start         = 1'b1;
    in_command    = cmd;
    in_key_weight = w;
    in_tag        = t;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (cmd == CMD_INSERT) begin
      insert_sent++;
      if (fill_level < HEAP_DEPTH - 1) fill_level++;
    end else begin
      pop_sent++;
      if (fill_level > 0) fill_level--;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 15);
    end
  endtask

  task automatic random_request(input int insert_pct);
    if ($urandom_range(0, 99) < insert_pct) issue_request(CMD_INSERT, pick_weight(), pick_tag());
    else issue_request(CMD_POP, WEIGHT_W'($urandom), TAG_BITS'($urandom));
  endtask

  task automatic wait_for_results();
    start = 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  initial begin
    rst_n         = 1'b0;
    start         = 1'b0;
    in_command    = CMD_INSERT;
    in_key_weight = '0;
    in_tag        = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pop, weight and tag extremes, equal weights, then drain past empty.
    issue_request(CMD_POP, '1, '1);
    issue_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    issue_request(CMD_INSERT, 32'h0000_0000, 16'h0000);
    issue_request(CMD_INSERT, 32'd5, 16'h0001);
    issue_request(CMD_INSERT, 32'd5, 16'h0002);
    issue_request(CMD_INSERT, 32'd5, 16'h0003);
    issue_request(CMD_INSERT, 32'h8000_0000, 16'h8000);
    issue_request(CMD_INSERT, 32'd1, 16'h5555);
    issue_request(CMD_INSERT, 32'hFFFF_FFFE, 16'hAAAA);
    repeat (9) issue_request(CMD_POP, WEIGHT_W'($urandom), TAG_BITS'($urandom));
    wait_for_results();
    @(negedge clk);

    repeat (60) random_request(50);

    while (fill_level < HEAP_DEPTH - 1) random_request(96);
    repeat (4) issue_request(CMD_INSERT, pick_weight(), pick_tag());
    wait_for_results();
    @(negedge clk);

    while (fill_level > 0) random_request(4);
    repeat (3) issue_request(CMD_POP, WEIGHT_W'($urandom), TAG_BITS'($urandom));

    wait_for_results();
    repeat (60) @(negedge clk);
    $display("Covered %0d requests: %0d inserts and %0d pops, filled to %0d entries.",
             insert_sent + pop_sent, insert_sent, pop_sent, HEAP_DEPTH - 1);
    $display("Inserts refused on a full heap: %0d; pops on an empty heap: %0d.",
             full_seen, empty_seen);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
